// ----- src/nfd_pkg.sv -----
// Shared constants and types for the nonuniform five-point derivative unit.
package nfd_pkg;

   // Default number of fraction bits in the fixed-point format.
   localparam int FRAC_BITS_DEFAULT = 16;

   // Width of one sample or abscissa, and of a difference of two of them.
   localparam int DATA_W = 32;
   localparam int MW     = DATA_W + 1;

   // Limb width used when splitting wide multiplications.
   localparam int LIMB_W = 32;

   // Quotient bits developed below the saturation check.
   localparam int QUOT_BITS = 33;

   // Saturation bounds of the result.
   localparam logic [DATA_W-1:0] DERIV_MAX = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] DERIV_MIN = 32'h8000_0000;

   // Sign and special-case flags that ride along with the divider operands.
   typedef struct packed {
      logic neg;
      logic coinc;
   } nfd_ctl_type;

   // One finished result beat.
   typedef struct packed {
      logic [DATA_W-1:0] derivative;
      logic              saturated;
      logic              coincident_nodes;
   } nfd_res_type;

endpackage

// ----- src/nfd_smul.sv -----
// Pipelined signed multiplier of a wide operand by a 33-bit operand.
module nfd_smul #(
   parameter int AW = 33
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [AW-1:0]           a,
   input  logic signed [nfd_pkg::MW-1:0]  b,
   output logic signed [AW+nfd_pkg::MW-1:0] p
);

   localparam int MW  = nfd_pkg::MW;
   localparam int LW  = nfd_pkg::LIMB_W;
   localparam int NL  = (AW + LW - 1) / LW;
   localparam int PPW = LW + MW;
   localparam int SW  = NL * LW + MW;

   logic [NL*LW-1:0]  ma_ff, ma_in;
   logic [MW-1:0]     mb_ff, mb_in;
   logic              sg1_ff, sg2_ff;
   logic [PPW-1:0]    pp_ff [0:NL-1];
   logic [PPW-1:0]    pp_in [0:NL-1];
   logic [AW-1:0]     a_mag;
   logic [SW-1:0]     grp0, grp1, grp2, mask, total;
   logic signed [AW+MW-1:0] p_ff, p_in;

   // Stage one: split both operands into sign and magnitude.
   always_comb begin
      a_mag = a[AW-1] ? (~a + 1'b1) : a;
      ma_in = (NL*LW)'(a_mag);
      mb_in = b[MW-1] ? (~b + 1'b1) : b;
   end

   // Stage two: one limb product per 32-bit slice of the wide magnitude.
   always_comb begin
      for (int i = 0; i < NL; i++) begin
         pp_in[i] = PPW'(ma_ff[i*LW +: LW]) * PPW'(mb_ff);
      end
   end

   // Stage three: limb products in three non-overlapping groups, summed with the sign applied.
   always_comb begin
      grp0 = '0;
      grp1 = '0;
      grp2 = '0;
      for (int i = 0; i < NL; i++) begin
         if (i % 3 == 0) begin
            grp0 = grp0 | (SW'(pp_ff[i]) << (LW * i));
         end else if (i % 3 == 1) begin
            grp1 = grp1 | (SW'(pp_ff[i]) << (LW * i));
         end else begin
            grp2 = grp2 | (SW'(pp_ff[i]) << (LW * i));
         end
      end
      mask  = {SW{sg2_ff}};
      total = (grp0 ^ mask) + (grp1 ^ mask) + (grp2 ^ mask) + (sg2_ff ? SW'(3) : SW'(0));
      p_in  = total[AW+MW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff  <= ma_in;
         mb_ff  <= mb_in;
         sg1_ff <= a[AW-1] ^ b[MW-1];
         for (int i = 0; i < NL; i++) begin
            pp_ff[i] <= pp_in[i];
         end
         sg2_ff <= sg1_ff;
         p_ff   <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// ----- src/nfd_div.sv -----
// Pipelined restoring divider with floor rounding, saturation and output register.
module nfd_div #(
   parameter int NW = 370,
   parameter int DW = 330
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [NW-1:0]        num,
   input  logic [DW-1:0]        den,
   input  nfd_pkg::nfd_ctl_type ctl,
   output nfd_pkg::nfd_res_type res
);

   localparam int QB = nfd_pkg::QUOT_BITS;
   localparam int CW = (NW > DW + QB + 1) ? NW : DW + QB + 1;
   localparam logic [QB:0] POS_LIM = (QB+1)'(33'h0_7fff_ffff);
   localparam logic [QB:0] NEG_LIM = (QB+1)'(33'h0_8000_0000);

   logic [CW-1:0]        rem_ff [0:QB];
   logic [CW-1:0]        rem_in [0:QB];
   logic [QB-1:0]        q_ff   [0:QB];
   logic [QB-1:0]        q_in   [0:QB];
   logic [DW-1:0]        dv_ff  [0:QB];
   logic                 sat_ff [0:QB];
   nfd_pkg::nfd_ctl_type ctl_ff [0:QB];
   logic [CW-1:0]        trial  [1:QB];
   logic [QB:0]          qa_ff, qa_in;
   logic                 sa_ff, sa_in;
   nfd_pkg::nfd_ctl_type ca_ff;
   nfd_pkg::nfd_res_type res_ff, res_in;

   // First step checks for a quotient of 2^33 or more, then one quotient bit per step.
   always_comb begin
      rem_in[0] = CW'(num);
      q_in[0]   = '0;
      for (int k = 1; k <= QB; k++) begin
         trial[k] = CW'(dv_ff[k-1]) << (QB - k);
         if (rem_ff[k-1] >= trial[k]) begin
            rem_in[k] = rem_ff[k-1] - trial[k];
            q_in[k]   = q_ff[k-1] | (QB'(1) << (QB - k));
         end else begin
            rem_in[k] = rem_ff[k-1];
            q_in[k]   = q_ff[k-1];
         end
      end
   end

   // Floor a negative quotient away from zero when a remainder is left, and flag saturation.
   always_comb begin
      qa_in = (QB+1)'(q_ff[QB]) + (QB+1)'(ctl_ff[QB].neg && (rem_ff[QB] != '0));
      sa_in = sat_ff[QB] || (ctl_ff[QB].neg ? (qa_in > NEG_LIM) : (qa_in > POS_LIM));
   end

   // Final clamp and the special case of coincident abscissae.
   always_comb begin
      res_in.coincident_nodes = ca_ff.coinc;
      if (ca_ff.coinc) begin
         res_in.derivative = '0;
         res_in.saturated  = 1'b0;
      end else if (sa_ff) begin
         res_in.derivative = ca_ff.neg ? nfd_pkg::DERIV_MIN : nfd_pkg::DERIV_MAX;
         res_in.saturated  = 1'b1;
      end else begin
         res_in.derivative = ca_ff.neg ? (~qa_ff[31:0] + 1'b1) : qa_ff[31:0];
         res_in.saturated  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         dv_ff[0]  <= den;
         sat_ff[0] <= CW'(num) >= (CW'(den) << QB);
         ctl_ff[0] <= ctl;
         for (int k = 1; k <= QB; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            dv_ff[k]  <= dv_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
            ctl_ff[k] <= ctl_ff[k-1];
         end
         qa_ff  <= qa_in;
         sa_ff  <= sa_in;
         ca_ff  <= ctl_ff[QB];
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ----- src/nonuniform_five_point_derivative_unit.sv -----
// Top level: first or second derivative of the five-point Lagrange interpolant.
// Throughput: one beat per cycle; the whole pipeline holds while a result waits unaccepted.
// The depth is set by the chained limb multiplies by 33-bit operands and the
// 34-step restoring divider.
// Reset clears only the valid bits; no clearing pass is needed.
module nonuniform_five_point_derivative_unit #(
   parameter int FRAC_BITS = nfd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // node_pos[2:0], grid_0..grid_4, value_0..value_4 (32 bits each), zero fill.
   input  logic [327:0] req_tdata,
   // kind.
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // derivative.
   output logic [31:0]  rsp_tdata,
   // saturated, coincident_nodes.
   output logic [1:0]   rsp_tuser
);

   localparam int MW   = nfd_pkg::MW;
   localparam int DW32 = nfd_pkg::DATA_W;
   localparam int EW   = 104;
   localparam int TW   = EW + 7 * MW;
   localparam int VW   = 10 * MW;
   localparam int SW   = TW + 3;
   localparam int NW   = SW + 2 * FRAC_BITS;
   localparam int RD   = 37;
   localparam int LAT  = 1 + RD + 1 + nfd_pkg::QUOT_BITS + 3;

   typedef struct packed {
      logic              kind;
      logic              coinc;
      logic [9:0][32:0]  d;
      logic [4:0][32:0]  a;
      logic [4:0][31:0]  u;
   } rec_type;

   // Position of the t-th stencil point other than j.
   function automatic int bsel(input int j, input int t);
      return (t < j) ? t : t + 1;
   endfunction

   // Index of the i-th point pair that leaves out point j.
   function automatic int dsel(input int j, input int i);
      int cnt;
      int idx;
      int r;
      cnt = 0;
      idx = 0;
      r   = 0;
      for (int m = 0; m < 5; m++) begin
         for (int n = m + 1; n < 5; n++) begin
            if (m != j && n != j) begin
               if (cnt == i) r = idx;
               cnt++;
            end
            idx++;
         end
      end
      return r;
   endfunction

   logic                   en;
   logic [LAT-1:0]         vld_ff;
   logic                   kind_ff;
   logic [2:0]             pos_ff;
   logic signed [DW32-1:0] x_ff [0:4];
   logic signed [DW32-1:0] u_ff [0:4];
   rec_type                rec_ff [0:RD-1];
   rec_type                rec_in;
   logic signed [DW32-1:0] xp;
   logic signed [TW-1:0]   tfin [0:4];
   logic signed [VW-1:0]   vv [0:9];
   logic signed [SW-1:0]   sa_ff, sb_ff, s_ff, sa_in, sb_in;
   logic signed [VW-1:0]   v35_ff, v36_ff;
   logic [SW-1:0]          s_mag;
   logic [VW-1:0]          v_mag;
   logic [NW-1:0]          num_ff, num_in;
   logic [VW-1:0]          den_ff;
   nfd_pkg::nfd_ctl_type   ctl_ff, ctl_in;
   nfd_pkg::nfd_res_type   res;

   // The pipeline advances unless a finished beat is waiting.
   assign en         = ~rsp_tvalid | rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff <= req_tuser;
         pos_ff  <= req_tdata[2:0];
         for (int i = 0; i < 5; i++) begin
            x_ff[i] <= req_tdata[3 + DW32*i +: DW32];
            u_ff[i] <= req_tdata[3 + DW32*(5 + i) +: DW32];
         end
      end
   end

   // Pairwise differences, offsets from the chosen node and the coincidence check.
   always_comb begin
      int k;
      k  = 0;
      xp = (pos_ff > 3'd4) ? x_ff[4] : x_ff[pos_ff];
      rec_in       = '0;
      rec_in.kind  = kind_ff;
      for (int m = 0; m < 5; m++) begin
         for (int n = m + 1; n < 5; n++) begin
            rec_in.d[k] = MW'(x_ff[n]) - MW'(x_ff[m]);
            if (x_ff[n] == x_ff[m]) rec_in.coinc = 1'b1;
            k++;
         end
      end
      for (int m = 0; m < 5; m++) begin
         rec_in.a[m] = MW'(xp) - MW'(x_ff[m]);
         rec_in.u[m] = u_ff[m];
      end
   end

   // Item record delay line, tapped by the lanes at their stage.
   always_ff @(posedge clock) begin
      if (en) begin
         rec_ff[0] <= rec_in;
         for (int s = 1; s < RD; s++) begin
            rec_ff[s] <= rec_ff[s-1];
         end
      end
   end

   // One lane per stencil point: symmetric polynomial of the node offsets, then
   // times the sample and the six differences that leave the point out.
   for (genvar j = 0; j < 5; j++) begin : g_lane
      logic signed [EW-1:0]    ei1 [0:2];
      logic signed [EW-1:0]    ei2 [0:2];
      logic signed [EW-1:0]    ei3 [0:2];
      logic signed [MW-1:0]    bi  [0:2];
      logic signed [EW+MW-1:0] m2  [0:2];
      logic signed [EW+MW-1:0] m3  [0:2];
      logic signed [EW-1:0]    d1_ff [0:2][0:2];
      logic signed [EW-1:0]    d2_ff [0:2][0:2];
      logic signed [EW-1:0]    d3_ff [0:2][0:2];
      logic signed [MW-1:0]    bd_ff [0:2][0:2];
      logic signed [EW-1:0]    e1_ff [1:3];
      logic signed [EW-1:0]    e2_ff [1:3];
      logic signed [EW-1:0]    e3_ff [1:3];
      logic signed [EW-1:0]    n_ff, n_in;
      logic signed [TW-1:0]    tv [0:7];

      // Recurrence state before each step; the first point seeds it.
      always_comb begin
         ei1[0] = EW'($signed(rec_ff[0].a[bsel(j, 0)]));
         ei2[0] = '0;
         ei3[0] = '0;
         for (int t = 1; t < 3; t++) begin
            ei1[t] = e1_ff[t];
            ei2[t] = e2_ff[t];
            ei3[t] = e3_ff[t];
         end
      end

      for (genvar t = 0; t < 3; t++) begin : g_estep
         assign bi[t] = $signed(rec_ff[4*t].a[bsel(j, t + 1)]);
         nfd_smul #(.AW(EW)) u_m2 (
            .clock (clock), .en (en), .a (ei1[t]), .b (bi[t]), .p (m2[t])
         );
         nfd_smul #(.AW(EW)) u_m3 (
            .clock (clock), .en (en), .a (ei2[t]), .b (bi[t]), .p (m3[t])
         );
      end

      // Align the state with the products, then fold in one more offset.
      always_ff @(posedge clock) begin
         if (en) begin
            for (int t = 0; t < 3; t++) begin
               d1_ff[t][0] <= ei1[t];
               d2_ff[t][0] <= ei2[t];
               d3_ff[t][0] <= ei3[t];
               bd_ff[t][0] <= bi[t];
               for (int k = 1; k < 3; k++) begin
                  d1_ff[t][k] <= d1_ff[t][k-1];
                  d2_ff[t][k] <= d2_ff[t][k-1];
                  d3_ff[t][k] <= d3_ff[t][k-1];
                  bd_ff[t][k] <= bd_ff[t][k-1];
               end
               e1_ff[t+1] <= d1_ff[t][2] + EW'(bd_ff[t][2]);
               e2_ff[t+1] <= d2_ff[t][2] + EW'(m2[t]);
               e3_ff[t+1] <= d3_ff[t][2] + EW'(m3[t]);
            end
            n_ff <= n_in;
         end
      end

      // Second derivative takes twice the pair sum, first takes the triple sum.
      assign n_in  = rec_ff[12].kind ? (e2_ff[3] <<< 1) : e3_ff[3];
      assign tv[0] = TW'(n_ff);

      for (genvar i = 0; i < 7; i++) begin : g_term
         logic signed [MW-1:0]          tb;
         logic signed [EW+MW*(i+1)-1:0] tp;
         if (i == 0) begin : g_u
            assign tb = MW'($signed(rec_ff[13].u[j]));
         end else begin : g_d
            assign tb = $signed(rec_ff[13 + 3*i].d[dsel(j, i - 1)]);
         end
         nfd_smul #(.AW(EW + MW*i)) u_mul (
            .clock (clock), .en (en), .a (tv[i][EW+MW*i-1:0]), .b (tb), .p (tp)
         );
         assign tv[i+1] = TW'(tp);
      end

      assign tfin[j] = tv[7];
   end

   // Product of all ten differences, started late so it lands with the lane terms.
   assign vv[0] = VW'($signed(rec_ff[7].d[0]));
   for (genvar i = 1; i < 10; i++) begin : g_vstep
      logic signed [MW*(i+1)-1:0] vp;
      nfd_smul #(.AW(MW*i)) u_mul (
         .clock (clock),
         .en    (en),
         .a     (vv[i-1][MW*i-1:0]),
         .b     ($signed(rec_ff[7 + 3*(i-1)].d[i])),
         .p     (vp)
      );
      assign vv[i] = VW'(vp);
   end

   // Alternating sum of the five lane terms over two stages.
   assign sa_in = SW'(tfin[0]) - SW'(tfin[1]) + SW'(tfin[2]);
   assign sb_in = SW'(tfin[4]) - SW'(tfin[3]);

   // Scale, sign and magnitudes for the divider.
   always_comb begin
      s_mag = s_ff[SW-1] ? (~s_ff + 1'b1) : s_ff;
      v_mag = v36_ff[VW-1] ? (~v36_ff + 1'b1) : v36_ff;
      if (rec_ff[RD-1].kind) begin
         num_in = NW'(s_mag) << (2 * FRAC_BITS);
      end else begin
         num_in = NW'(s_mag) << FRAC_BITS;
      end
      ctl_in.neg   = s_ff[SW-1] ^ v36_ff[VW-1];
      ctl_in.coinc = rec_ff[RD-1].coinc;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff  <= sa_in;
         sb_ff  <= sb_in;
         v35_ff <= vv[9];
         s_ff   <= sa_ff + sb_ff;
         v36_ff <= v35_ff;
         num_ff <= num_in;
         den_ff <= v_mag;
         ctl_ff <= ctl_in;
      end
   end

   nfd_div #(.NW(NW), .DW(VW)) u_div (
      .clock (clock),
      .en    (en),
      .num   (num_ff),
      .den   (den_ff),
      .ctl   (ctl_ff),
      .res   (res)
   );

   assign rsp_tdata = res.derivative;
   assign rsp_tuser = {res.coincident_nodes, res.saturated};

`ifndef SYNTHESIS
   // Coincident abscissae give a zero, unsaturated derivative.
   a_coinc_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0 && !rsp_tuser[0])
      else $error("coincident result not zero");

   // A saturated result sits on one of the two bounds.
   a_sat_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata == nfd_pkg::DERIV_MAX || rsp_tdata == nfd_pkg::DERIV_MIN)
      else $error("saturated result off the bounds");

   // An accepted beat enters the valid pipeline.
   a_accept_vld : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted beat lost");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the nonuniform five-point derivative unit.
module tb;

   typedef logic signed [511:0] wide_type;
   typedef logic signed [31:0] q16_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [327:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   nfd_pkg::nfd_res_type pending_results[$];
   int          error_count = 0;
   bit          no_idle = 1'b0;
   int          stall_left = 0;

   nonuniform_five_point_derivative_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #1 clock = ~clock;

   // Exact derivative of the Lagrange interpolant, floored and saturated to Q16.16.
   function automatic nfd_pkg::nfd_res_type predict_derivative(input bit kind,
                                                      input logic [2:0] pos,
                                                      input q16_type g[5],
                                                      input q16_type v[5]);
      nfd_pkg::nfd_res_type res;
      wide_type    xw[5], ofs[5];
      wide_type    denom, total, term, esym, part, mag, quot, rem;
      int          p, cnt;
      bit          neg, sat;
      res = '0;
      p = (pos > 3'd4) ? 4 : int'(pos);
      for (int i = 0; i < 5; i++) xw[i] = g[i];
      for (int m = 0; m < 5; m++)
         for (int n = m + 1; n < 5; n++)
            if (xw[m] == xw[n]) begin
               res.coincident_nodes = 1'b1;
               return res;
            end
      for (int m = 0; m < 5; m++) ofs[m] = xw[p] - xw[m];
      denom = 1;
      for (int m = 0; m < 5; m++)
         for (int n = m + 1; n < 5; n++) denom = denom * (xw[n] - xw[m]);
      total = 0;
      for (int j = 0; j < 5; j++) begin
         term = v[j];
         for (int m = 0; m < 5; m++)
            for (int n = m + 1; n < 5; n++)
               if (m != j && n != j) term = term * (xw[n] - xw[m]);
         // Elementary symmetric sum of the node offsets, skipping point j.
         esym = 0;
         for (int mask = 0; mask < 32; mask++) begin
            if (mask[j]) continue;
            cnt = $countones(mask[4:0]);
            if (cnt != 3 - kind) continue;
            part = 1;
            for (int m = 0; m < 5; m++) if (mask[m]) part = part * ofs[m];
            esym = esym + part;
         end
         term = term * esym;
         if (j % 2 == 1) total = total - term;
         else total = total + term;
      end
      if (kind) total = total <<< 1;
      total = total <<< (nfd_pkg::FRAC_BITS_DEFAULT * (kind + 1));
      if (denom < 0) begin
         denom = -denom;
         total = -total;
      end
      neg = total < 0;
      mag = neg ? -total : total;
      sat = 1'b0;
      if (mag >= (denom <<< 33)) sat = 1'b1;
      else begin
         quot = mag / denom;
         rem = mag % denom;
         if (neg && rem != 0) quot = quot + 1;
         if (neg && quot > 64'sd2147483648) sat = 1'b1;
         if (!neg && quot > 64'sd2147483647) sat = 1'b1;
      end
      if (sat) res.derivative = neg ? nfd_pkg::DERIV_MIN : nfd_pkg::DERIV_MAX;
      else res.derivative = neg ? -quot[31:0] : quot[31:0];
      res.saturated = sat;
      return res;
   endfunction

   // Drive one stencil beat and record its expected result once accepted.
   task automatic send_stencil(input bit kind, input logic [2:0] pos,
                               input q16_type g[5], input q16_type v[5]);
      logic [327:0] packed_beat;
      packed_beat = '0;
      packed_beat[2:0] = pos;
      for (int i = 0; i < 5; i++) begin
         packed_beat[3 + 32*i +: 32] = g[i];
         packed_beat[163 + 32*i +: 32] = v[i];
      end
      @(negedge clock);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tdata = packed_beat;
      req_tuser = kind;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_derivative(kind, pos, g, v));
   endtask

   // Grid with random steps or fully random, and values of random magnitude.
   task automatic send_random_stencil();
      q16_type g[5], v[5];
      int   sh;
      if ($urandom_range(0, 4) == 0) begin
         for (int i = 0; i < 5; i++) begin
            g[i] = $urandom;
            v[i] = $urandom;
         end
         if ($urandom_range(0, 9) == 0) g[$urandom_range(1, 4)] = g[0];
      end else begin
         sh = $urandom_range(0, 24);
         g[0] = $urandom >>> $urandom_range(0, 31);
         for (int i = 1; i < 5; i++)
            g[i] = g[i-1] + ($urandom_range(1, 1 << sh) * ($urandom_range(0, 3) == 0 ? -1 : 1));
         sh = $urandom_range(0, 31);
         for (int i = 0; i < 5; i++) v[i] = $signed($urandom) >>> sh;
      end
      send_stencil(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), g, v);
   endtask

   // Compare each accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      nfd_pkg::nfd_res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result beat: derivative %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.derivative) begin
               $error("derivative: expected %h, got %h", want.derivative, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[0] !== want.saturated) begin
               $error("saturated: expected %b, got %b", want.saturated, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tuser[1] !== want.coincident_nodes) begin
               $error("coincident_nodes: expected %b, got %b",
                      want.coincident_nodes, rsp_tuser[1]);
               error_count++;
            end
         end
      end
   end

   // Result-side backpressure in random bursts.
   always @(negedge clock) begin
      if (no_idle || reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 6) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Extremes of the fields, every node position and both kinds.
   task automatic test_directed();
      q16_type g[5], v[5];
      for (int k = 0; k < 2; k++)
         for (int p = 0; p < 8; p++) begin
            g = '{32'sh0, 32'sh10000, 32'sh30000, 32'sh40000, 32'sh80000};
            v = '{32'sh10000, -32'sh20000, 32'sh7fffffff, 32'sh0, -32'sh80000000};
            send_stencil(1'(k), 3'(p), g, v);
         end
      // Widest grid span.
      g = '{-32'sh80000000, -32'sh1, 32'sh0, 32'sh1, 32'sh7fffffff};
      v = '{32'sh7fffffff, -32'sh80000000, 32'shffffffff, 32'sh7fffffff, 32'sh1};
      send_stencil(1'b0, 3'd0, g, v);
      send_stencil(1'b1, 3'd4, g, v);
      // Tiny spacing with large samples forces saturation both ways.
      g = '{32'sh0, 32'sh1, 32'sh2, 32'sh3, 32'sh4};
      v = '{32'sh7fffffff, -32'sh80000000, 32'sh7fffffff, -32'sh80000000, 32'sh7fffffff};
      send_stencil(1'b0, 3'd2, g, v);
      send_stencil(1'b1, 3'd2, g, v);
      send_stencil(1'b0, 3'd1, g, v);
      // Coincident abscissae.
      g = '{32'sh0, 32'sh10000, 32'sh10000, 32'sh30000, 32'sh40000};
      send_stencil(1'b0, 3'd2, g, v);
      g = '{32'sh7fffffff, 32'sh10000, 32'sh20000, 32'sh30000, 32'sh7fffffff};
      send_stencil(1'b1, 3'd7, g, v);
   endtask

   // Random stencils, with one full drain of the pipeline midway.
   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_random_stencil();
         if (i == count / 2) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
         end
      end
   endtask

   // Back-to-back stencils with no idling on either side.
   task automatic test_full_rate(input int count);
      no_idle = 1'b1;
      for (int i = 0; i < count; i++) send_random_stencil();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(1200);
      test_full_rate(200);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Run limit.
   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
